### hw/rtl/quadrature_knob_with_press_timer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quadrature knob / press timer block
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_KNOB_WITH_PRESS_TIMER_TOP_MACROS_SVH
`define QUADRATURE_KNOB_WITH_PRESS_TIMER_TOP_MACROS_SVH

// Same-cycle implication.
`define QKPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QKPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qkpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qkpt_pkg
// Shared types and codes for the quadrature knob / press timer block.
// ---------------------------------------------------------------------------
package qkpt_pkg;

  localparam int unsigned THR_W   = 16;
  localparam int unsigned EVENT_W = 2;

  // Threshold after reset.
  localparam logic [THR_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // Phase patterns (bit1, bit0).
  localparam logic [1:0] PH_00 = 2'b00;
  localparam logic [1:0] PH_01 = 2'b01;
  localparam logic [1:0] PH_10 = 2'b10;
  localparam logic [1:0] PH_11 = 2'b11;

  // turn_event codes
  localparam logic [EVENT_W-1:0] TURN_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] TURN_LEFT  = 2'd1;
  localparam logic [EVENT_W-1:0] TURN_RIGHT = 2'd2;

  // press_event codes
  localparam logic [EVENT_W-1:0] PRESS_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] PRESS_SHORT = 2'd1;
  localparam logic [EVENT_W-1:0] PRESS_LONG  = 2'd2;

  // One accepted sample, handed to both machines.
  typedef struct packed {
    logic       adv;
    logic [1:0] phase_bits;
    logic       button_level;
  } qkpt_step_t;

endpackage

### hw/rtl/quadrature_knob_with_press_timer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_knob_with_press_timer_top
// Quadrature knob detent decoder plus push-button short/long press timer.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready | phase_bits, button_level
//  out_    | out | out_tvalid/out_tready | turn_event, press_event
//  cfg_    | in  | cfg_we (no wait)      | long_press_ticks
//
//  One item in, one item out, registered; a new item every cycle unless a held result stalls.
//  The sample updates both state machines and lands in the result register
//  in the same cycle; the result register is the only pipeline stage.
//  in_tready is low during reset; after that it drops only while a result
//  is held and out_tready is low.
//  rst_n (sync, active low) clears both machines, the hold count and the
//  result valid, and loads long_press_ticks with 1000.
//
module quadrature_knob_with_press_timer_top (
  input  logic       clk,
  input  logic       rst_n,
  // input samples
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [1:0] phase_bits, [2] button_level, [7:3] zero
  // results
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] turn_event, [3:2] press_event, [7:4] zero
  // threshold register
  input  logic                       cfg_we,
  input  logic [qkpt_pkg::THR_W-1:0] cfg_wdata
);
  import qkpt_pkg::*;

  logic                 out_valid_r;
  logic [THR_W-1:0]     thr_r;
  logic                 in_acc;
  qkpt_step_t           step;
  logic [EVENT_W-1:0]   turn_event;
  logic [EVENT_W-1:0]   press_event;

  // Result register frees up when taken, so accepts overlap with drains.
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign step.adv          = in_acc;
  assign step.phase_bits   = in_tdata[1:0];
  assign step.button_level = in_tdata[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      thr_r       <= LONG_PRESS_RESET;
    end else begin
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  qkpt_turn u_turn (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .turn_event (turn_event)
  );

  qkpt_press u_press (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .long_press_ticks (thr_r),
    .press_event      (press_event)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, press_event, turn_event};

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
`include "quadrature_knob_with_press_timer_top_macros.svh"

  // every accepted sample produces a result the next cycle
  `QKPT_ASSERT_NEXT(a_acc_gives_result, in_acc, out_tvalid, "accepted item produced no result")

  // a held button can never yield a short press
  `QKPT_ASSERT_NEXT(a_short_needs_release, in_acc && in_tdata[2],
    out_tdata[3:2] != PRESS_SHORT, "short press reported while button held")

  // a detent completes only on the 00 pattern
  `QKPT_ASSERT_NEXT(a_detent_on_00, in_acc && (in_tdata[1:0] != PH_00),
    out_tdata[1:0] == TURN_NONE, "detent reported off the 00 pattern")

  // no undefined event codes on the bus
  `QKPT_ASSERT_SAME(a_codes_legal, out_tvalid,
    (out_tdata[1:0] != 2'd3) && (out_tdata[3:2] != 2'd3), "undefined event code")

endmodule

### hw/rtl/qkpt_turn.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qkpt_turn
// Gray-sequence detent tracker; registers one turn event per sample.
// ---------------------------------------------------------------------------
module qkpt_turn (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qkpt_pkg::qkpt_step_t    step,
  output logic [qkpt_pkg::EVENT_W-1:0] turn_event
);
  import qkpt_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'd0,
    T_L1   = 3'd1,
    T_L2   = 3'd2,
    T_L3   = 3'd3,
    T_R1   = 3'd5,
    T_R2   = 3'd6,
    T_R3   = 3'd7
  } turn_state_t;

  turn_state_t          state_r, state_nxt;
  logic [EVENT_W-1:0]   ev_r, ev_nxt;

  always_comb begin
    state_nxt = state_r;
    ev_nxt    = TURN_NONE;
    case (state_r)
      T_L1: begin
        if (step.phase_bits == PH_11) state_nxt = T_L2;
        else if (step.phase_bits == PH_10) state_nxt = T_IDLE;
      end
      T_L2: begin
        if (step.phase_bits == PH_10) state_nxt = T_L3;
        else if (step.phase_bits == PH_01) state_nxt = T_IDLE;
      end
      T_L3: begin
        if (step.phase_bits == PH_00) begin
          ev_nxt    = TURN_LEFT;
          state_nxt = T_IDLE;
        end else if (step.phase_bits == PH_11) begin
          state_nxt = T_IDLE;
        end
      end
      T_R1: begin
        if (step.phase_bits == PH_11) state_nxt = T_R2;
        else if (step.phase_bits == PH_01) state_nxt = T_IDLE;
      end
      T_R2: begin
        if (step.phase_bits == PH_01) state_nxt = T_R3;
        else if (step.phase_bits == PH_10) state_nxt = T_IDLE;
      end
      T_R3: begin
        if (step.phase_bits == PH_00) begin
          ev_nxt    = TURN_RIGHT;
          state_nxt = T_IDLE;
        end else if (step.phase_bits == PH_11) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        // idle, and the unreachable code 4
        if (step.phase_bits == PH_01) state_nxt = T_L1;
        else if (step.phase_bits == PH_10) state_nxt = T_R1;
        else state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ev_r    <= TURN_NONE;
    end else if (step.adv) begin
      state_r <= state_nxt;
      ev_r    <= ev_nxt;
    end
  end

  assign turn_event = ev_r;

endmodule

### hw/rtl/qkpt_press.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qkpt_press
// Button hold timer; registers one short/long press event per sample.
// ---------------------------------------------------------------------------
module qkpt_press (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qkpt_pkg::qkpt_step_t         step,
  input  logic [qkpt_pkg::THR_W-1:0]   long_press_ticks,
  output logic [qkpt_pkg::EVENT_W-1:0] press_event
);
  import qkpt_pkg::*;

  typedef enum logic [1:0] {
    P_RELEASED = 2'd0,
    P_TIMING   = 2'd1,
    P_WAIT     = 2'd2
  } press_state_t;

  press_state_t         state_r, state_nxt;
  logic [THR_W-1:0]     held_r, held_nxt, held_inc;
  logic [EVENT_W-1:0]   ev_r, ev_nxt;

  // saturating increment
  assign held_inc = (held_r == {THR_W{1'b1}}) ? held_r : held_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    ev_nxt    = PRESS_NONE;
    case (state_r)
      P_RELEASED: begin
        if (step.button_level) state_nxt = P_TIMING;
      end
      P_TIMING: begin
        if (step.button_level) begin
          held_nxt = held_inc;
          if (held_inc > long_press_ticks) begin
            ev_nxt    = PRESS_LONG;
            state_nxt = P_WAIT;
          end
        end else begin
          ev_nxt    = PRESS_SHORT;
          state_nxt = P_WAIT;
        end
      end
      default: begin
        // waiting for release, and the unreachable code 3
        if (!step.button_level) begin
          state_nxt = P_RELEASED;
          held_nxt  = '0;
        end else begin
          state_nxt = P_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_RELEASED;
      held_r  <= '0;
      ev_r    <= PRESS_NONE;
    end else if (step.adv) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ev_r    <= ev_nxt;
    end
  end

  assign press_event = ev_r;

endmodule
